// ----- src/u8dv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8dv_pkg;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_STRAY_CONT = 4'd1,
		ST_TRUNCATED  = 4'd2,
		ST_CONT_EXP   = 4'd3,
		ST_OVERLONG   = 4'd4,
		ST_SURROGATE  = 4'd5,
		ST_BAD_LEAD   = 4'd6,
		ST_NULL_IN    = 4'd7,
		ST_NULL_MISS  = 4'd8
	} status_t;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned CNT_W = 32;

	localparam logic [CP_W-1:0]  CP_MIN_2B   = 21'h00080;
	localparam logic [CP_W-1:0]  CP_MIN_3B   = 21'h00800;
	localparam logic [CP_W-1:0]  CP_MIN_4B   = 21'h10000;
	localparam logic [CP_W-1:0]  CP_LIMIT    = 21'h110000;
	localparam logic [CP_W-1:0]  CP_SURR_LO  = 21'h0D800;
	localparam logic [CP_W-1:0]  CP_SURR_HI  = 21'h0DFFF;
	localparam logic [CNT_W-1:0] CNT_MAX     = 32'hFFFF_FFFF;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] LEAD_BAD = 8'hF8;
	localparam logic [7:0] ASCII_END = 8'h80;
	localparam logic [1:0] CONT_TAG = 2'b10;

	typedef struct packed {
		logic [CP_W-1:0]  partial;
		logic [1:0]       need;
		logic [1:0]       seq_len;
		logic             pend_bad;
		logic             discard;
		logic [CNT_W-1:0] count;
	} dec_state_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             has_code_point;
		status_t          status;
		logic             done_res;
		logic [CNT_W-1:0] code_point_count;
	} dec_res_t;

endpackage

`default_nettype wire

// ----- src/u8dv_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface u8dv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- src/u8dv_cp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface u8dv_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        has_code_point;
	logic [3:0]  status;
	logic        done_res;
	logic [31:0] code_point_count;

	modport source (output valid, output code_point, output has_code_point, output status,
		output done_res, output code_point_count, input ready);
	modport sink (input valid, input code_point, input has_code_point, input status,
		input done_res, input code_point_count, output ready);
endinterface

`default_nettype wire

// ----- src/u8dv_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8dv_step import u8dv_pkg::*; (
	input  dec_state_t cur,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	input  logic       null_terminated,
	output dec_state_t nxt,
	output logic       emit,
	output dec_res_t   res
);

	logic             is_cont;
	logic             pend_n;
	logic [CP_W-1:0]  part_n;
	logic [1:0]       need_n;
	logic [CNT_W-1:0] cnt_inc;

	assign is_cont = (byte_value[7:6] == CONT_TAG);
	assign pend_n  = cur.pend_bad | ~is_cont;
	assign part_n  = (is_cont && !cur.pend_bad) ? {cur.partial[CP_W-7:0], byte_value[5:0]}
		: cur.partial;
	assign need_n  = cur.need - 2'd1;
	assign cnt_inc = (cur.count == CNT_MAX) ? cur.count : cur.count + 32'd1;

	dec_state_t zero_st;
	assign zero_st = '0;

	logic            do_err;
	status_t         err_code;
	logic            do_pt;
	logic [CP_W-1:0] pt_val;

	always_comb begin
		nxt      = cur;
		do_err   = 1'b0;
		err_code = ST_OK;
		do_pt    = 1'b0;
		pt_val   = '0;
		if (cur.discard) begin
			if (last_byte) begin
				nxt = zero_st;
			end
		end else if (cur.need != 2'd0) begin
			nxt.pend_bad = pend_n;
			nxt.partial  = part_n;
			nxt.need     = need_n;
			if (need_n != 2'd0) begin
				if (last_byte) begin
					do_err   = 1'b1;
					err_code = ST_TRUNCATED;
				end
			end else if (pend_n) begin
				do_err   = 1'b1;
				err_code = ST_CONT_EXP;
			end else begin
				case (cur.seq_len)
					2'd1: begin
						if (part_n < CP_MIN_2B) begin
							do_err   = 1'b1;
							err_code = ST_OVERLONG;
						end
					end
					2'd2: begin
						if (part_n < CP_MIN_3B) begin
							do_err   = 1'b1;
							err_code = ST_OVERLONG;
						end else if (part_n >= CP_SURR_LO && part_n <= CP_SURR_HI) begin
							do_err   = 1'b1;
							err_code = ST_SURROGATE;
						end
					end
					default: begin
						if (part_n < CP_MIN_4B || part_n >= CP_LIMIT) begin
							do_err   = 1'b1;
							err_code = ST_OVERLONG;
						end
					end
				endcase
				if (!do_err) begin
					do_pt  = 1'b1;
					pt_val = part_n;
				end
			end
		end else if (byte_value < ASCII_END) begin
			if (byte_value == 8'd0 && null_terminated && !last_byte) begin
				do_err   = 1'b1;
				err_code = ST_NULL_IN;
			end else begin
				do_pt  = 1'b1;
				pt_val = {13'd0, byte_value};
			end
		end else if (byte_value < LEAD_2B) begin
			do_err   = 1'b1;
			err_code = ST_STRAY_CONT;
		end else if (byte_value >= LEAD_BAD) begin
			do_err   = 1'b1;
			err_code = ST_BAD_LEAD;
		end else if (last_byte) begin
			do_err   = 1'b1;
			err_code = ST_TRUNCATED;
		end else begin
			nxt.pend_bad = 1'b0;
			if (byte_value < LEAD_3B) begin
				nxt.partial = {16'd0, byte_value[4:0]};
				nxt.need    = 2'd1;
				nxt.seq_len = 2'd1;
			end else if (byte_value < LEAD_4B) begin
				nxt.partial = {17'd0, byte_value[3:0]};
				nxt.need    = 2'd2;
				nxt.seq_len = 2'd2;
			end else begin
				nxt.partial = {18'd0, byte_value[2:0]};
				nxt.need    = 2'd3;
				nxt.seq_len = 2'd3;
			end
		end

		res  = '0;
		emit = do_err | do_pt;
		if (do_err) begin
			res.status           = err_code;
			res.done_res         = 1'b1;
			res.code_point_count = cur.count;
			nxt                  = zero_st;
			nxt.discard          = ~last_byte;
		end else if (do_pt) begin
			res.code_point       = pt_val;
			res.has_code_point   = 1'b1;
			res.status           = (last_byte && null_terminated && pt_val != '0)
				? ST_NULL_MISS : ST_OK;
			res.done_res         = last_byte;
			res.code_point_count = cnt_inc;
			nxt                  = zero_st;
			if (!last_byte) begin
				nxt.count = cnt_inc;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/utf8_decoder_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to code point decoder with validation. One source byte is taken per
// cycle with no bubbles while the output register is empty or being read: a
// byte lands in an input register, is decoded combinationally against the
// sequence state and its result, if any, is written to an output register; a
// result thus goes through the input register, then the output register.
// The input side keeps accepting while the output register holds a result that
// has not been taken, as long as that result is taken in the same cycle. Bytes
// that only extend a sequence, and bytes dropped after an error, give no result.
// Write null_terminated only while no byte is in flight.

module utf8_decoder_validator import u8dv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	u8dv_byte_if.sink        utf8,
	u8dv_cp_if.source        utf32
);

	logic       null_term_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	logic       emit;
	dec_res_t   res;
	logic       out_valid_q;
	dec_res_t   out_q;
	logic       advance;

	assign advance    = valid_s1 && (!out_valid_q || utf32.ready);
	assign utf8.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_term_q <= 1'b0;
		end else if (cfg_we) begin
			null_term_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (utf8.ready) begin
			valid_s1 <= utf8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (utf8.valid && utf8.ready) begin
			byte_s1 <= utf8.byte_value;
			last_s1 <= utf8.last_byte;
		end
	end

	u8dv_step u_step (
		.cur             (state_q),
		.byte_value      (byte_s1),
		.last_byte       (last_s1),
		.null_terminated (null_term_q),
		.nxt             (state_nxt),
		.emit            (emit),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (utf32.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign utf32.valid            = out_valid_q;
	assign utf32.code_point       = out_q.code_point;
	assign utf32.has_code_point   = out_q.has_code_point;
	assign utf32.status           = out_q.status;
	assign utf32.done_res         = out_q.done_res;
	assign utf32.code_point_count = out_q.code_point_count;

`ifndef SYNTHESIS
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		utf32.valid && !utf32.has_code_point |-> utf32.done_res)
		else $error("error word without done");

	a_cp_range: assert property (@(posedge clk) disable iff (!arst_n)
		utf32.valid && utf32.has_code_point |->
		(utf32.code_point < CP_LIMIT) &&
		!(utf32.code_point >= CP_SURR_LO && utf32.code_point <= CP_SURR_HI))
		else $error("code point out of range or surrogate");

	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.discard |-> (state_q.need == 2'd0) && (state_q.count == '0))
		else $error("discard with live sequence state");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!utf8.ready |-> valid_s1 && out_valid_q && !utf32.ready)
		else $error("input stalled without full output");
`endif

endmodule

`default_nettype wire

// ----- bench/utf8_decoder_validator_tb.sv -----
`timescale 1ns / 1ps

module utf8_decoder_validator_tb;
	import u8dv_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	u8dv_byte_if byte_ch ();
	u8dv_cp_if   cp_ch ();

	utf8_decoder_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.utf8     (byte_ch),
		.utf32    (cp_ch)
	);

	word_t      tx_words[$];
	dec_res_t   cp_expect_q[$];
	logic [7:0] str_buf[$];

	logic        nt_mode;
	logic [20:0] acc_cp;
	logic [1:0]  need_cnt;
	logic [1:0]  seq_len;
	logic        bad_cont;
	logic        discard;
	logic [31:0] cp_count;

	int cycle_cnt = 0;
	int err_cnt = 0;
	int queued_words = 0;
	int src_idle = 0;
	int sink_idle = 0;
	bit idle_en = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void clear_string();
		acc_cp   = '0;
		need_cnt = '0;
		seq_len  = '0;
		bad_cont = 1'b0;
		discard  = 1'b0;
		cp_count = '0;
	endfunction

	function automatic void expect_point(logic [20:0] cp, logic lst);
		dec_res_t r;
		if (cp_count != CNT_MAX)
			cp_count = cp_count + 1;
		r.code_point       = cp;
		r.has_code_point   = 1'b1;
		r.status           = (lst && nt_mode && cp != '0) ? ST_NULL_MISS : ST_OK;
		r.done_res         = lst;
		r.code_point_count = cp_count;
		cp_expect_q.push_back(r);
		acc_cp   = '0;
		need_cnt = '0;
		seq_len  = '0;
		bad_cont = 1'b0;
		if (lst)
			clear_string();
	endfunction

	function automatic void expect_error(status_t code, logic lst);
		dec_res_t r;
		r.code_point       = '0;
		r.has_code_point   = 1'b0;
		r.status           = code;
		r.done_res         = 1'b1;
		r.code_point_count = cp_count;
		cp_expect_q.push_back(r);
		clear_string();
		if (!lst)
			discard = 1'b1;
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic lst);
		if (discard) begin
			if (lst)
				clear_string();
			return;
		end
		if (need_cnt != 0) begin
			if (b[7:6] != CONT_TAG)
				bad_cont = 1'b1;
			else if (!bad_cont)
				acc_cp = {acc_cp[14:0], b[5:0]};
			need_cnt = need_cnt - 2'd1;
			if (need_cnt != 0) begin
				if (lst)
					expect_error(ST_TRUNCATED, lst);
				return;
			end
			if (bad_cont) begin
				expect_error(ST_CONT_EXP, lst);
				return;
			end
			case (seq_len)
				2'd1: begin
					if (acc_cp < CP_MIN_2B) begin
						expect_error(ST_OVERLONG, lst);
						return;
					end
				end
				2'd2: begin
					if (acc_cp < CP_MIN_3B) begin
						expect_error(ST_OVERLONG, lst);
						return;
					end
					if (acc_cp >= CP_SURR_LO && acc_cp <= CP_SURR_HI) begin
						expect_error(ST_SURROGATE, lst);
						return;
					end
				end
				default: begin
					if (acc_cp < CP_MIN_4B || acc_cp >= CP_LIMIT) begin
						expect_error(ST_OVERLONG, lst);
						return;
					end
				end
			endcase
			expect_point(acc_cp, lst);
			return;
		end
		if (b < ASCII_END) begin
			if (b == 8'h00 && nt_mode && !lst)
				expect_error(ST_NULL_IN, lst);
			else
				expect_point({13'd0, b}, lst);
			return;
		end
		if (b < LEAD_2B) begin
			expect_error(ST_STRAY_CONT, lst);
			return;
		end
		if (b >= LEAD_BAD) begin
			expect_error(ST_BAD_LEAD, lst);
			return;
		end
		if (lst) begin
			expect_error(ST_TRUNCATED, lst);
			return;
		end
		if (b < LEAD_3B) begin
			acc_cp   = {16'd0, b[4:0]};
			need_cnt = 2'd1;
		end else if (b < LEAD_4B) begin
			acc_cp   = {17'd0, b[3:0]};
			need_cnt = 2'd2;
		end else begin
			acc_cp   = {18'd0, b[2:0]};
			need_cnt = 2'd3;
		end
		seq_len  = need_cnt;
		bad_cont = 1'b0;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_cnt++;
		$display("cycle %0d: %s: got %0h, want %0h", cycle_cnt, what, got, want);
	endtask

	task automatic check_word();
		dec_res_t e;
		if (cp_expect_q.size() == 0) begin
			report_mismatch("unexpected word", 32'(cp_ch.code_point), 32'd0);
			return;
		end
		e = cp_expect_q.pop_front();
		if (cp_ch.code_point !== e.code_point)
			report_mismatch("code_point", 32'(cp_ch.code_point), 32'(e.code_point));
		if (cp_ch.has_code_point !== e.has_code_point)
			report_mismatch("has_code_point", 32'(cp_ch.has_code_point),
				32'(e.has_code_point));
		if (cp_ch.status !== e.status)
			report_mismatch("status", 32'(cp_ch.status), 32'(e.status));
		if (cp_ch.done_res !== e.done_res)
			report_mismatch("done_res", 32'(cp_ch.done_res), 32'(e.done_res));
		if (cp_ch.code_point_count !== e.code_point_count)
			report_mismatch("code_point_count", cp_ch.code_point_count, e.code_point_count);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_words
		word_t nxt;
		if (!arst_n) begin
			byte_ch.valid      <= 1'b0;
			byte_ch.byte_value <= 8'h00;
			byte_ch.last_byte  <= 1'b0;
			src_idle = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				decode_byte(byte_ch.byte_value, byte_ch.last_byte);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (src_idle > 0)
					src_idle--;
				else if (idle_en && tx_words.size() != 0 && $urandom_range(0, 15) == 0)
					src_idle = $urandom_range(1, 19);
				if (src_idle == 0 && tx_words.size() != 0) begin
					nxt = tx_words.pop_front();
					byte_ch.valid      <= 1'b1;
					byte_ch.byte_value <= nxt.value;
					byte_ch.last_byte  <= nxt.last;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : take_words
		if (!arst_n) begin
			cp_ch.ready <= 1'b0;
			sink_idle = 0;
		end else begin
			if (cp_ch.valid && cp_ch.ready)
				check_word();
			if (sink_idle > 0)
				sink_idle--;
			else if (idle_en && $urandom_range(0, 15) == 0)
				sink_idle = $urandom_range(1, 19);
			cp_ch.ready <= (sink_idle == 0);
		end
	end

	function automatic void flush_string();
		word_t w;
		for (int i = 0; i < str_buf.size(); i++) begin
			w.value = str_buf[i];
			w.last  = (i == str_buf.size() - 1);
			tx_words.push_back(w);
		end
		queued_words += str_buf.size();
		str_buf.delete();
	endfunction

	function automatic void add_cp(logic [20:0] v, int unsigned len);
		case (len)
			1: str_buf.push_back({1'b0, v[6:0]});
			2: begin
				str_buf.push_back({3'b110, v[10:6]});
				str_buf.push_back({2'b10, v[5:0]});
			end
			3: begin
				str_buf.push_back({4'b1110, v[15:12]});
				str_buf.push_back({2'b10, v[11:6]});
				str_buf.push_back({2'b10, v[5:0]});
			end
			default: begin
				str_buf.push_back({5'b11110, v[20:18]});
				str_buf.push_back({2'b10, v[17:12]});
				str_buf.push_back({2'b10, v[11:6]});
				str_buf.push_back({2'b10, v[5:0]});
			end
		endcase
	endfunction

	function automatic void add_valid_cp();
		logic [20:0] v;
		case ($urandom_range(0, 3))
			0: add_cp(21'(nt_mode ? $urandom_range(1, 'h7F) : $urandom_range(0, 'h7F)), 1);
			1: add_cp(21'($urandom_range('h80, 'h7FF)), 2);
			2: begin
				v = 21'($urandom_range('h800, 'hFFFF));
				if (v >= CP_SURR_LO && v <= CP_SURR_HI)
					v = v ^ 21'h02000;
				add_cp(v, 3);
			end
			default: add_cp(21'($urandom_range('h10000, 'h10FFFF)), 4);
		endcase
	endfunction

	function automatic void add_bad_piece();
		case ($urandom_range(0, 6))
			0: add_cp(21'($urandom_range(0, 'h7F)), 2);
			1: add_cp(21'($urandom_range(0, 'h7FF)), 3);
			2: add_cp(21'($urandom_range(0, 'hFFFF)), 4);
			3: add_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
			4: add_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
			5: str_buf.push_back(8'($urandom_range('h80, 'hBF)));
			default: str_buf.push_back(8'($urandom_range('hF8, 'hFF)));
		endcase
	endfunction

	function automatic void add_random_string();
		int unsigned n;
		int unsigned pick;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		for (int unsigned k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 85)
				add_valid_cp();
			else if ($urandom_range(0, 3) == 0)
				str_buf.push_back(8'($urandom_range(0, 255)));
			else
				add_bad_piece();
		end
		pick = $urandom_range(0, 99);
		if (pick < 8 && str_buf.size() > 1)
			void'(str_buf.pop_back());
		else if (pick < 16)
			str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(0, 255));
		if (nt_mode && $urandom_range(0, 9) != 0)
			str_buf.push_back(8'h00);
		flush_string();
	endfunction

	task automatic add_random_words(int count);
		int target;
		target = queued_words + count;
		while (queued_words < target)
			add_random_string();
	endtask

	task automatic drain();
		while (tx_words.size() != 0 || byte_ch.valid || cp_expect_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_mode(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		nt_mode = v;
		@(negedge clk);
	endtask

	initial begin
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		arst_n             = 1'b0;
		nt_mode            = 1'b0;
		clear_string();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		str_buf = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
			8'hE0, 8'hA0, 8'h80};
		flush_string();
		str_buf = '{8'h80, 8'h41, 8'hFF};
		flush_string();
		str_buf = '{8'hF8};
		flush_string();
		str_buf = '{8'hC0, 8'h80};
		flush_string();
		str_buf = '{8'hED, 8'hA0, 8'h80};
		flush_string();
		str_buf = '{8'hE2, 8'h41};
		flush_string();
		str_buf = '{8'hC3, 8'h41};
		flush_string();
		str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
		flush_string();
		add_random_words(330);
		drain();

		write_mode(1'b1);
		str_buf = '{8'h41, 8'h00, 8'h00};
		flush_string();
		str_buf = '{8'h41};
		flush_string();
		str_buf = '{8'h41, 8'h00};
		flush_string();
		add_random_words(300);
		drain();

		write_mode(1'b0);
		add_random_words(250);
		drain();

		write_mode(1'b1);
		idle_en = 1'b0;
		add_random_words(150);
		drain();
		repeat (8) @(negedge clk);

		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
src/u8dv_pkg.sv
src/u8dv_byte_if.sv
src/u8dv_cp_if.sv
src/u8dv_step.sv
src/utf8_decoder_validator.sv
bench/utf8_decoder_validator_tb.sv
